// File: src/sb2da_pkg.sv
package sb2da_pkg;

	// Widths of the conversion datapath
	localparam int MagWidth      = 32;
	localparam int DigitCount    = 10;
	localparam int BcdWidth      = 4 * DigitCount;
	localparam int StepsPerStage = 8;
	localparam int LenWidth      = 4;

	// ASCII codes emitted on the character port
	localparam logic [7:0] AsciiMinus = 8'h2D;
	localparam logic [3:0] AsciiDigitHigh = 4'h3;

	// Converted item handed from the conversion pipe to the serializer
	typedef struct packed {
		logic                neg;
		logic [BcdWidth-1:0] bcd;
	} bcd_word_t;

endpackage

// File: src/sb2da_convert_pipe.sv
module sb2da_convert_pipe (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [sb2da_pkg::MagWidth-1:0] value,
	output logic                                 in_ready,
	output logic                                 out_valid,
	output sb2da_pkg::bcd_word_t                 out_word,
	input  logic                                 out_ready
);

	typedef struct packed {
		logic [sb2da_pkg::BcdWidth-1:0] bcd;
		logic [sb2da_pkg::MagWidth-1:0] bin;
	} dabble_t;

	// Eight shift-and-add-3 steps, one input bit each, MSB first
	function automatic dabble_t dabble_steps(input dabble_t d_in);
		dabble_t d;
		d = d_in;
		for (int s = 0; s < sb2da_pkg::StepsPerStage; s++) begin
			for (int k = 0; k < sb2da_pkg::DigitCount; k++) begin
				if (d.bcd[4*k +: 4] >= 4'd5) begin
					d.bcd[4*k +: 4] = d.bcd[4*k +: 4] + 4'd3;
				end
			end
			d = {d.bcd[sb2da_pkg::BcdWidth-2:0], d.bin, 1'b0};
		end
		return d;
	endfunction

	logic                            valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                            neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [sb2da_pkg::MagWidth-1:0]  mag_s1;
	dabble_t                         word_s2, word_s3, word_s4, word_s5;
	logic                            ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;
	logic [sb2da_pkg::MagWidth-1:0]  bits;
	dabble_t                         next_s2, next_s3, next_s4, next_s5;

	// Backpressure: a stage takes data when empty or when it moves on
	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign bits    = value;
	assign next_s2 = dabble_steps('{bcd: '0, bin: mag_s1});
	assign next_s3 = dabble_steps(word_s2);
	assign next_s4 = dabble_steps(word_s3);
	assign next_s5 = dabble_steps(word_s4);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: sign and magnitude; stages 2-5: eight dabble steps each
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			neg_s1 <= bits[sb2da_pkg::MagWidth-1];
			mag_s1 <= bits[sb2da_pkg::MagWidth-1] ? (sb2da_pkg::MagWidth'(0) - bits) : bits;
		end
		if (ready_s2 && valid_s1) begin
			neg_s2  <= neg_s1;
			word_s2 <= next_s2;
		end
		if (ready_s3 && valid_s2) begin
			neg_s3  <= neg_s2;
			word_s3 <= next_s3;
		end
		if (ready_s4 && valid_s3) begin
			neg_s4  <= neg_s3;
			word_s4 <= next_s4;
		end
		if (ready_s5 && valid_s4) begin
			neg_s5  <= neg_s4;
			word_s5 <= next_s5;
		end
	end

	assign out_valid    = valid_s5;
	assign out_word.neg = neg_s5;
	assign out_word.bcd = word_s5.bcd;

endmodule

// File: src/sb2da_serializer.sv
module sb2da_serializer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  sb2da_pkg::bcd_word_t                in_word,
	output logic                                in_ready,
	output logic                                strobe,
	output logic [7:0]                          character,
	output logic [sb2da_pkg::LenWidth-1:0]      total_length,
	output logic                                last
);

	logic [sb2da_pkg::LenWidth-1:0] rem_q;
	logic [sb2da_pkg::LenWidth-1:0] len_q;
	logic                           minus_q;
	logic [sb2da_pkg::BcdWidth-1:0] digits_q;
	logic [sb2da_pkg::LenWidth-1:0] ndig;
	logic [sb2da_pkg::LenWidth-1:0] lead;
	logic                           load;

	// Significant digit count, at least one
	always_comb begin
		ndig = sb2da_pkg::LenWidth'(1);
		for (int k = 0; k < sb2da_pkg::DigitCount; k++) begin
			if (in_word.bcd[4*k +: 4] != 4'd0) begin
				ndig = sb2da_pkg::LenWidth'(k + 1);
			end
		end
		lead = sb2da_pkg::LenWidth'(sb2da_pkg::DigitCount) - ndig;
	end

	// Take a new item while idle or while the last character goes out
	assign in_ready = (rem_q == '0) || (rem_q == sb2da_pkg::LenWidth'(1));
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= ndig + sb2da_pkg::LenWidth'(in_word.neg);
		end else if (rem_q != '0) begin
			rem_q <= rem_q - sb2da_pkg::LenWidth'(1);
		end
	end

	// Digits left-aligned so the next one is always the top nibble
	always_ff @(posedge clk) begin
		if (load) begin
			len_q    <= ndig + sb2da_pkg::LenWidth'(in_word.neg);
			minus_q  <= in_word.neg;
			digits_q <= in_word.bcd << {lead, 2'b00};
		end else if (rem_q != '0) begin
			if (minus_q) begin
				minus_q <= 1'b0;
			end else begin
				digits_q <= {digits_q[sb2da_pkg::BcdWidth-5:0], 4'd0};
			end
		end
	end

	assign strobe       = (rem_q != '0);
	assign character    = minus_q ? sb2da_pkg::AsciiMinus
	                              : {sb2da_pkg::AsciiDigitHigh,
	                                 digits_q[sb2da_pkg::BcdWidth-1 -: 4]};
	assign total_length = len_q;
	assign last         = (rem_q == sb2da_pkg::LenWidth'(1));

endmodule

// File: src/signed_binary_to_decimal_ascii.sv
// Path: an item taken with start passes the conversion pipe stages s1 to s5 in order and is then
// loaded into the serializer, which puts its first character on the ports.
// Throughput: each item leaves as total_length characters (1 to 11) from the one-character-per-cycle
// serializer; the five-stage conversion pipe accepts a new item every cycle while it has room.
// busy is high while the pipe is full behind the serializer; the receiver cannot stall.
// Reset: arst_n clears all valid bits and the character count; no item is in flight after it.
module signed_binary_to_decimal_ascii (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [sb2da_pkg::MagWidth-1:0] value,
	output logic                                  busy,
	output logic                                  strobe,
	output logic [7:0]                            character,
	output logic [sb2da_pkg::LenWidth-1:0]        total_length,
	output logic                                  last
);

	logic                 pipe_ready;
	logic                 conv_valid;
	logic                 ser_ready;
	sb2da_pkg::bcd_word_t conv_word;

	assign busy = !pipe_ready;

	// Sign, magnitude and binary-to-BCD conversion
	sb2da_convert_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.value     (value),
		.in_ready  (pipe_ready),
		.out_valid (conv_valid),
		.out_word  (conv_word),
		.out_ready (ser_ready)
	);

	// One character per cycle, minus sign first
	sb2da_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (conv_valid),
		.in_word      (conv_word),
		.in_ready     (ser_ready),
		.strobe       (strobe),
		.character    (character),
		.total_length (total_length),
		.last         (last)
	);

endmodule

// File: src/sb2da_checker.sv
module sb2da_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  strobe,
	input logic [7:0]                            character,
	input logic [sb2da_pkg::LenWidth-1:0]        total_length,
	input logic                                  last
);

	// A string runs without gaps until its last character
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("character run broken before last");

	// Length is the same on every character of a string
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> total_length == $past(total_length))
		else $error("total_length changed within a string");

	// A one-character string ends on its first character
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && total_length == 4'd1 |-> last)
		else $error("single-character string without last");

	// Only a minus sign or a digit is emitted, and a minus never ends a string
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == sb2da_pkg::AsciiMinus && !last) ||
		           (character[7:4] == sb2da_pkg::AsciiDigitHigh && character[3:0] <= 4'd9))
		else $error("bad character emitted");

endmodule

bind signed_binary_to_decimal_ascii sb2da_checker u_chk (.*);

// File: test/tb_signed_binary_to_decimal_ascii.sv
module tb_signed_binary_to_decimal_ascii;

	localparam int DirCount  = 20;
	localparam int RandItems = 480;
	localparam int MaxChars  = 11;
	localparam int DrainWait = 24;

	// One character of converted text as it should leave the block
	typedef struct packed {
		logic [7:0]                     ch;
		logic [sb2da_pkg::LenWidth-1:0] len;
		logic                           fin;
	} text_char_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  start;
	logic signed [sb2da_pkg::MagWidth-1:0] value;
	logic                                  busy;
	logic                                  strobe;
	logic [7:0]                            character;
	logic [sb2da_pkg::LenWidth-1:0]        total_length;
	logic                                  last;

	text_char_t pending_chars[$];
	int         error_count = 0;

	// Directed items; an empty text means the predictor supplies it
	logic signed [sb2da_pkg::MagWidth-1:0] dir_value [DirCount] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd100,
		32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
		-32'sd1000000000, 32'sd999999999, 32'sd1000000007, 32'h5555_5555,
		32'hAAAA_AAAA, 32'sd101010, -32'sd300, 32'h0000_FFFF
	};
	string dir_text [DirCount] = '{
		"0", "1", "-1", "9", "-9", "10", "-10", "100",
		"2147483647", "-2147483648", "-2147483647", "1000000000",
		"-1000000000", "999999999", "1000000007", "",
		"", "", "", ""
	};

	signed_binary_to_decimal_ascii dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.value        (value),
		.busy         (busy),
		.strobe       (strobe),
		.character    (character),
		.total_length (total_length),
		.last         (last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Run limit
	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	// Decimal text of a signed 32-bit value, queued one character per entry
	task automatic predict_decimal(input logic [sb2da_pkg::MagWidth-1:0] bits);
		logic [sb2da_pkg::MagWidth-1:0] mag;
		logic [7:0]                     digits [sb2da_pkg::DigitCount];
		logic [7:0]                     text [MaxChars];
		int                             ndig;
		int                             len;
		begin
			mag  = bits[sb2da_pkg::MagWidth-1] ? (32'd0 - bits) : bits;
			ndig = 0;
			len  = 0;
			do begin
				digits[ndig] = {sb2da_pkg::AsciiDigitHigh, 4'(mag % 10)};
				ndig++;
				mag = mag / 10;
			end while (mag != 0 && ndig < sb2da_pkg::DigitCount);
			if (bits[sb2da_pkg::MagWidth-1]) begin
				text[len] = sb2da_pkg::AsciiMinus;
				len++;
			end
			for (int k = ndig - 1; k >= 0; k--) begin
				text[len] = digits[k];
				len++;
			end
			for (int k = 0; k < len; k++)
				pending_chars.push_back('{text[k], sb2da_pkg::LenWidth'(len), k == len - 1});
		end
	endtask

	// Typed-in text for the obvious directed rows
	task automatic expect_text(input string s);
		for (int k = 0; k < s.len(); k++)
			pending_chars.push_back('{s[k], sb2da_pkg::LenWidth'(s.len()), k == s.len() - 1});
	endtask

	// Hold one item on the ports until taken, then idle for gap cycles
	task automatic send_item(input logic signed [sb2da_pkg::MagWidth-1:0] v,
			input string text, input int gap);
		begin
			start <= 1'b1;
			value <= v;
			do @(posedge clk); while (busy);
			if (text.len() != 0)
				expect_text(text);
			else
				predict_decimal(v);
			if (gap > 0) begin
				start <= 1'b0;
				value <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic int pick_gap(input bit burst);
		int r;
		begin
			r = $urandom_range(0, 99);
			if (burst || r < 55)
				return 0;
			else if (r < 92)
				return $urandom_range(1, 3);
			else
				return $urandom_range(10, 60);
		end
	endfunction

	// Random value with a spread of digit counts, boundaries and raw bits
	function automatic logic signed [sb2da_pkg::MagWidth-1:0] pick_value();
		longint p;
		longint mag;
		int     k;
		bit     neg;
		begin
			neg = $urandom_range(0, 1);
			p   = 1;
			case ($urandom_range(0, 9))
				0, 1: return $urandom;
				2: mag = $urandom_range(0, 20);
				3: begin
					k = $urandom_range(0, 9);
					repeat (k) p = p * 10;
					mag = p + $urandom_range(0, 2) - 1;
				end
				4: begin
					if (neg)
						return 32'h8000_0000 + $urandom_range(0, 3);
					return 32'h7FFF_FFFF - $urandom_range(0, 3);
				end
				default: begin
					k = $urandom_range(1, 10);
					repeat (k - 1) p = p * 10;
					mag = p + longint'($urandom) % (p * 9);
					if (mag > 64'sd2147483647)
						mag = 64'sd2147483647;
				end
			endcase
			return neg ? -mag[31:0] : mag[31:0];
		end
	endfunction

	// Result checker: every strobe must match the oldest queued character
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected character", character, 0);
			end else begin
				want = pending_chars.pop_front();
				if (character !== want.ch)
					report_mismatch("character", character, want.ch);
				if (total_length !== want.len)
					report_mismatch("total_length", total_length, want.len);
				if (last !== want.fin)
					report_mismatch("last", last, want.fin);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		value  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table
		for (int i = 0; i < DirCount; i++)
			send_item(dir_value[i], dir_text[i], pick_gap(i < 8));

		// Hold off until the directed text has fully drained
		start <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);

		// Random items, with stretches of back-to-back traffic
		for (int i = 0; i < RandItems; i++) begin
			send_item(pick_value(), "", pick_gap((i / 40) % 3 == 1));
			if (i == RandItems / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_chars.size() != 0);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
		repeat (DrainWait) @(posedge clk);

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
